// File: design/rme_pkg.sv
// Package for the rotation matrix to Euler angle core.
// Request and response structs, CORDIC constants and arctangent table.
`timescale 1ns / 1ps
package rme_pkg;
   localparam int CordicSteps = 14;
   localparam int AccW = 27;
   localparam int ZW = 20;
   localparam logic [14:0] PoleLimitReset = 15'd16351;

   typedef struct packed {
      logic signed [15:0] m_row0_col0;
      logic signed [15:0] m_row0_col2;
      logic signed [15:0] m_row1_col0;
      logic signed [15:0] m_row1_col1;
      logic signed [15:0] m_row1_col2;
      logic signed [15:0] m_row2_col0;
      logic signed [15:0] m_row2_col2;
   } req_type;

   typedef struct packed {
      logic signed [14:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] roll_angle;
      logic at_pole;
   } rsp_type;

   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      case (i)
         0: atan_q16 = 20'sd51472;
         1: atan_q16 = 20'sd30385;
         2: atan_q16 = 20'sd16055;
         3: atan_q16 = 20'sd8150;
         4: atan_q16 = 20'sd4091;
         5: atan_q16 = 20'sd2047;
         6: atan_q16 = 20'sd1024;
         7: atan_q16 = 20'sd512;
         8: atan_q16 = 20'sd256;
         9: atan_q16 = 20'sd128;
         10: atan_q16 = 20'sd64;
         11: atan_q16 = 20'sd32;
         12: atan_q16 = 20'sd16;
         13: atan_q16 = 20'sd8;
         14: atan_q16 = 20'sd4;
         15: atan_q16 = 20'sd2;
         16: atan_q16 = 20'sd1;
         default: atan_q16 = '0;
      endcase
   endfunction
endpackage

// File: design/rme_cordic.sv
// Pipelined vectoring CORDIC atan2, one rotation per stage.
// Uses rme_pkg; result in Q3.13 clamped to plus or minus pi, 0 for a zero vector.
`timescale 1ns / 1ps
module rme_cordic (
   input  logic clock,
   input  logic signed [17:0] in_y,
   input  logic signed [17:0] in_x,
   output logic signed [15:0] out_angle
);
   import rme_pkg::*;
   localparam int N = CordicSteps + 1;

   logic signed [AccW-1:0] x_ff [N];
   logic signed [AccW-1:0] y_ff [N];
   logic signed [ZW-1:0] z_ff [N];
   logic zero_ff [N];
   logic signed [ZW-1:0] zr;

   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == 0) && (in_y == 0);
      if (in_x < 0) begin
         x_ff[0] <= -(AccW'(in_x) <<< 8);
         y_ff[0] <= -(AccW'(in_y) <<< 8);
         z_ff[0] <= (in_y >= 0) ? 20'sd205887 : -20'sd205887;
      end else begin
         x_ff[0] <= AccW'(in_x) <<< 8;
         y_ff[0] <= AccW'(in_y) <<< 8;
         z_ff[0] <= '0;
      end
      for (int k = 1; k < N; k++) begin
         zero_ff[k] <= zero_ff[k-1];
         if (y_ff[k-1] > 0) begin
            x_ff[k] <= x_ff[k-1] + (y_ff[k-1] >>> (k-1));
            y_ff[k] <= y_ff[k-1] - (x_ff[k-1] >>> (k-1));
            z_ff[k] <= z_ff[k-1] + atan_q16(k-1);
         end else begin
            x_ff[k] <= x_ff[k-1] - (y_ff[k-1] >>> (k-1));
            y_ff[k] <= y_ff[k-1] + (x_ff[k-1] >>> (k-1));
            z_ff[k] <= z_ff[k-1] - atan_q16(k-1);
         end
      end
   end

   always_comb begin
      zr = (z_ff[N-1] + 20'sd4) >>> 3;
      if (zero_ff[N-1]) out_angle = '0;
      else if (zr > 20'sd25736) out_angle = 16'sd25736;
      else if (zr < -20'sd25736) out_angle = -16'sd25736;
      else out_angle = zr[15:0];
   end
endmodule

// File: design/rotation_matrix_to_euler_core.sv
// Top level of the rotation matrix to Euler angle core (Z-X-Y order).
// Uses rme_pkg and three rme_cordic pipelines.
`timescale 1ns / 1ps
// A request is taken in every cycle; busy is always low. Twenty register stages
// lie between a request and its response: the input register, three stages of
// a pipelined integer square root, one stage forming the CORDIC operands,
// 14 CORDIC rotation stages, and the output register. The receiver cannot
// stall, so each response must be captured in the cycle it is shown.
module rotation_matrix_to_euler_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  rme_pkg::req_type req_data,
   input  logic csr_write,
   input  logic [14:0] csr_data,
   output logic rsp_valid,
   output rme_pkg::rsp_type rsp_data
);
   import rme_pkg::*;
   localparam int SqD = 3;
   localparam int CD = CordicSteps + 1;

   logic [14:0] pole_limit_ff;
   req_type r_ff [SqD+1];
   logic v_ff [SqD+1];
   logic [28:0] rem_ff [SqD+1];
   logic [14:0] root_ff [SqD+1];
   logic signed [15:0] s_ff [SqD+1];
   logic pole_ff [SqD+1];
   logic pole_d_ff [CD];
   logic vout_ff [CD];
   logic signed [17:0] ya_in, xa_in, yb_in, xb_in, sp_in, cp_in;
   logic signed [15:0] yaw_a, roll_a, pitch_a;
   logic [15:0] mag;
   logic signed [15:0] sc;
   logic [28:0] rem_n [SqD+1];
   logic [14:0] root_n [SqD+1];

   assign busy = 1'b0;
   assign mag = req_data.m_row1_col2[15] ? 16'(-17'(req_data.m_row1_col2))
                                       : {1'b0, req_data.m_row1_col2[14:0]};
   always_comb begin
      if (req_data.m_row1_col2 > 16'sd16384) sc = 16'sd16384;
      else if (req_data.m_row1_col2 < -16'sd16384) sc = -16'sd16384;
      else sc = req_data.m_row1_col2;
   end

   // Bit-by-bit square root, five result bits per stage.
   always_comb begin
      for (int k = 0; k <= SqD; k++) begin
         rem_n[k] = rem_ff[k];
         root_n[k] = root_ff[k];
      end
      for (int k = 0; k < SqD; k++) begin
         logic [28:0] rr;
         logic [14:0] q;
         rr = rem_ff[k];
         q = root_ff[k];
         for (int b = 0; b < 5; b++) begin
            int bit_i;
            logic [29:0] trial;
            bit_i = 14 - 5*k - b;
            trial = 30'((q << (bit_i + 1)) | (30'd1 << (2*bit_i)));
            if ({1'b0, rr} >= trial) begin
               rr = rr - trial[28:0];
               q = q | (15'd1 << bit_i);
            end
         end
         rem_n[k+1] = rr;
         root_n[k+1] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_limit_ff <= PoleLimitReset;
         for (int k = 0; k <= SqD; k++) v_ff[k] <= 1'b0;
         for (int k = 0; k < CD; k++) vout_ff[k] <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write) pole_limit_ff <= csr_data;
         v_ff[0] <= start;
         for (int k = 1; k <= SqD; k++) v_ff[k] <= v_ff[k-1];
         vout_ff[0] <= v_ff[SqD];
         for (int k = 1; k < CD; k++) vout_ff[k] <= vout_ff[k-1];
         rsp_valid <= vout_ff[CD-1];
      end
      r_ff[0] <= req_data;
      s_ff[0] <= sc;
      pole_ff[0] <= mag > {1'b0, pole_limit_ff};
      rem_ff[0] <= 29'd268435456 - 29'($signed(32'(sc)) * $signed(32'(sc)));
      root_ff[0] <= '0;
      for (int k = 1; k <= SqD; k++) begin
         r_ff[k] <= r_ff[k-1];
         s_ff[k] <= s_ff[k-1];
         pole_ff[k] <= pole_ff[k-1];
         rem_ff[k] <= rem_n[k];
         root_ff[k] <= root_n[k];
      end
      pole_d_ff[0] <= pole_ff[SqD];
      for (int k = 1; k < CD; k++) pole_d_ff[k] <= pole_d_ff[k-1];
      rsp_data.yaw_angle <= yaw_a;
      rsp_data.roll_angle <= pole_d_ff[CD-1] ? 16'sd0 : roll_a;
      if (pitch_a > 16'sd12868) rsp_data.pitch_angle <= 15'sd12868;
      else if (pitch_a < -16'sd12868) rsp_data.pitch_angle <= -15'sd12868;
      else rsp_data.pitch_angle <= pitch_a[14:0];
      rsp_data.at_pole <= pole_d_ff[CD-1];
   end

   always_comb begin
      if (pole_ff[SqD]) begin
         ya_in = -18'(r_ff[SqD].m_row2_col0);
         xa_in = 18'(r_ff[SqD].m_row0_col0);
      end else begin
         ya_in = -18'(r_ff[SqD].m_row0_col2);
         xa_in = 18'(r_ff[SqD].m_row2_col2);
      end
      yb_in = -18'(r_ff[SqD].m_row1_col0);
      xb_in = 18'(r_ff[SqD].m_row1_col1);
      sp_in = 18'(s_ff[SqD]);
      cp_in = 18'($signed({1'b0, root_ff[SqD]}));
   end

   rme_cordic u_yaw (.clock, .in_y(ya_in), .in_x(xa_in), .out_angle(yaw_a));
   rme_cordic u_roll (.clock, .in_y(yb_in), .in_x(xb_in), .out_angle(roll_a));
   rme_cordic u_pitch (.clock, .in_y(sp_in), .in_x(cp_in), .out_angle(pitch_a));
endmodule

// File: tb/sv/tb_rotation_matrix_to_euler_core.sv
// Testbench for rotation_matrix_to_euler_core: directed table plus random requests,
// checked against a behavioral predictor of the Z-X-Y Euler conversion.
// Depends on rme_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler_core;
   import rme_pkg::*;

   localparam int PiQ16 = 205887;
   localparam int PiQ13 = 25736;
   localparam int HalfPiQ13 = 12868;
   localparam int LatencyCycles = 20;
   localparam int WatchdogLimit = 4000;
   localparam int RandomRequests = 1450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic csr_write = 1'b0;
   logic [14:0] csr_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;

   rotation_matrix_to_euler_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_write(csr_write), .csr_data(csr_data), .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [14:0] pole_limit_q = PoleLimitReset;
   rsp_type angles_pending[$];
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int pole_hits = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;

   // Stimulus table: a row with has_exp set also carries a typed-in response.
   typedef struct {
      req_type req;
      bit has_exp;
      rsp_type exp;
   } table_row_type;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic int clamp_to(longint v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return int'(v);
   endfunction

   function automatic int vector_angle(int y, int x);
      longint xx, yy, z, dx, dy;
      xx = longint'(x) * 256;
      yy = longint'(y) * 256;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (xx < 0) begin
         xx = -xx;
         yy = -yy;
         z = (y >= 0) ? PiQ16 : -PiQ16;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         dx = floor_shr(yy, i);
         dy = floor_shr(xx, i);
         if (yy > 0) begin
            xx += dx;
            yy -= dy;
            z += longint'(atan_q16(i));
         end else begin
            xx -= dx;
            yy += dy;
            z -= longint'(atan_q16(i));
         end
      end
      return clamp_to(floor_shr(z + 4, 3), PiQ13);
   endfunction

   // Square root by bisection keeps the predictor fast over 1450 requests.
   function automatic int floor_sqrt(longint n);
      longint lo, hi, mid;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid - 1;
      end
      return int'(lo);
   endfunction

   function automatic rsp_type euler_angles(req_type r, logic [14:0] lim);
      rsp_type o;
      int m12, mag, s, c, pitch, yaw, roll;
      bit pole;
      m12 = int'(r.m_row1_col2);
      mag = (m12 < 0) ? -m12 : m12;
      pole = mag > int'(lim);
      if (pole) begin
         yaw = vector_angle(-int'(r.m_row2_col0), int'(r.m_row0_col0));
         roll = 0;
      end else begin
         yaw = vector_angle(-int'(r.m_row0_col2), int'(r.m_row2_col2));
         roll = vector_angle(-int'(r.m_row1_col0), int'(r.m_row1_col1));
      end
      s = m12;
      if (s > 16384) s = 16384;
      if (s < -16384) s = -16384;
      c = floor_sqrt(longint'(16384) * 16384 - longint'(s) * s);
      pitch = clamp_to(vector_angle(s, c), HalfPiQ13);
      o.pitch_angle = pitch[14:0];
      o.yaw_angle = yaw[15:0];
      o.roll_angle = roll[15:0];
      o.at_pole = pole;
      return o;
   endfunction

   function automatic req_type random_matrix();
      req_type r;
      r = req_type'(112'({$urandom, $urandom, $urandom, $urandom}));
      case ($urandom_range(0, 5))
         0: r.m_row1_col2 = 16'($signed($urandom_range(0, 800)) - 400 + 16351);
         1: r.m_row1_col2 = 16'(-($signed($urandom_range(0, 800)) - 400 + 16351));
         2: r.m_row1_col2 = 16'($signed($urandom_range(0, 32768)) - 16384);
         default: ;
      endcase
      if ($urandom_range(0, 7) == 0) begin
         r.m_row0_col0 = '0;
         r.m_row2_col0 = '0;
      end
      if ($urandom_range(0, 7) == 0) begin
         r.m_row1_col0 = '0;
         r.m_row1_col1 = '0;
      end
      return r;
   endfunction

   // Checks every response; the receiver cannot stall, so capture each strobe.
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid) begin
         if (angles_pending.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_data);
            errors++;
         end else begin
            exp = angles_pending.pop_front();
            checked++;
            if (rsp_data.pitch_angle !== exp.pitch_angle) begin
               $error("pitch_angle expected %0d actual %0d", exp.pitch_angle,
                      rsp_data.pitch_angle);
               errors++;
            end
            if (rsp_data.yaw_angle !== exp.yaw_angle) begin
               $error("yaw_angle expected %0d actual %0d", exp.yaw_angle,
                      rsp_data.yaw_angle);
               errors++;
            end
            if (rsp_data.roll_angle !== exp.roll_angle) begin
               $error("roll_angle expected %0d actual %0d", exp.roll_angle,
                      rsp_data.roll_angle);
               errors++;
            end
            if (rsp_data.at_pole !== exp.at_pole) begin
               $error("at_pole expected %0d actual %0d", exp.at_pole, rsp_data.at_pole);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without an accepted request or response.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("rotation_matrix_to_euler_core test failed");
         $finish;
      end
   end

   // Offers one request, idling the sender beforehand at the current rate,
   // and records the expectation when the core takes it.
   task automatic send_request(req_type r, bit has_exp, rsp_type exp);
      rsp_type pred;
      while ($urandom_range(1, 100) <= sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = euler_angles(r, pole_limit_q);
      if (has_exp && pred !== exp) begin
         $error("table row disagrees with predictor: table %h predictor %h", exp, pred);
         errors++;
      end
      angles_pending.push_back(pred);
      accepted++;
      if (pred.at_pole) pole_hits++;
   endtask

   task automatic drain_and_set_limit(logic [14:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (angles_pending.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 2) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      pole_limit_q = value;
   endtask

   function automatic table_row_type mk_row(int a, int b, int c, int d, int e, int f,
                                            int g, bit has_exp, int p, int y, int rl,
                                            bit pole);
      table_row_type t;
      t.req = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g)};
      t.has_exp = has_exp;
      t.exp = '{15'(p), 16'(y), 16'(rl), pole};
      return t;
   endfunction

   table_row_type directed[$];
   logic [14:0] limits[5] = '{15'd16384, 15'd0, 15'd32767, 15'd8000, PoleLimitReset};
   rsp_type none = '0;

   initial begin
      // Identity, all zeros, saturated pitch element, pole boundary, extremes.
      // A zero angle comes out of the CORDIC as -1 after rounding.
      directed.push_back(mk_row(16384, 0, 0, 16384, 0, 0, 16384, 1, -1, -1, -1, 0));
      directed.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 1, -1, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, 0, 32767, 0, 0, 1, 12867, 0, 0, 1));
      directed.push_back(mk_row(0, 0, 0, 0, -32768, 0, 0, 1, -12867, 0, 0, 1));
      directed.push_back(mk_row(16384, 0, 0, 16384, 16351, 0, 16384, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(16384, 0, 0, 16384, 16352, 0, 16384, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(16384, 0, 0, 16384, -16352, 0, 16384, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(-16384, 0, 0, -16384, 0, 0, -16384, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(-32768, 32767, -32768, 32767, 0, -32768, -32768,
                                0, 0, 0, 0, 0));
      directed.push_back(mk_row(32767, -32768, 32767, -32768, 16384, 32767, 32767,
                                0, 0, 0, 0, 0));
      directed.push_back(mk_row(-1, 1, 1, -1, -16384, 1, -1, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(-16384, 0, 0, -16384, 16384, 0, 16384, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 16384, 16384, 0, 100, -16384, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(-16384, 0, 0, -16384, 0, 1, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555,
                                16'hAAAA, 16'h5555, 0, 0, 0, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_request(directed[i].req, directed[i].has_exp,
                                         directed[i].exp);

      for (int phase = 0; phase < 5; phase++) begin
         drain_and_set_limit(limits[phase]);
         for (int n = 0; n < RandomRequests / 5; n++) begin
            // Sender idle rate is drawn at random from none, 57 and 35 percent
            // and redrawn every 97 requests.
            if (n % 97 == 0)
               case ($urandom_range(0, 2))
                  0: sender_idle_pct = 0;
                  1: sender_idle_pct = 57;
                  default: sender_idle_pct = 35;
               endcase
            send_request(random_matrix(), 1'b0, none);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (angles_pending.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 5) @(posedge clock);

      $display("covered %0d requests (%0d at the pole) over 6 pole limit settings",
               accepted, pole_hits);
      $display("%0d responses compared, %0d mismatches", checked, errors);
      if (errors == 0 && angles_pending.size() == 0) begin
         $display("rotation_matrix_to_euler_core test passed");
      end else begin
         $display("rotation_matrix_to_euler_core test failed");
      end
      $finish;
   end
endmodule

// File: files.f
design/rme_pkg.sv
design/rme_cordic.sv
design/rotation_matrix_to_euler_core.sv
tb/sv/tb_rotation_matrix_to_euler_core.sv
